// File: rtl/core/tcsm_pkg.sv
// Shared types and codes for the Type-C connection state machine.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tcsm_pkg;

  // Termination codes driven on CC.
  localparam logic [1:0] CC_OPEN = 2'd0;
  localparam logic [1:0] CC_RD   = 2'd1;
  localparam logic [1:0] CC_RP   = 2'd2;
  localparam logic [1:0] CC_TOG  = 2'd3;

  // Sampled CC status codes.
  localparam logic [2:0] CCS_OPEN = 3'd0;
  localparam logic [2:0] CCS_RD   = 3'd1;

  // Connection event codes.
  localparam logic [1:0] EVT_NONE     = 2'd0;
  localparam logic [1:0] EVT_TRY      = 2'd1;
  localparam logic [1:0] EVT_ATTACHED = 2'd2;
  localparam logic [1:0] EVT_DETACHED = 2'd3;

  // Role mode and toggle result codes.
  localparam logic [1:0] ROLE_SRC    = 2'd1;
  localparam logic [1:0] ROLE_DRP    = 2'd2;
  localparam logic [1:0] TOG_SNK     = 2'd1;
  localparam logic [1:0] TOG_SRC     = 2'd2;

  // Option flag bit positions.
  localparam int OPT_DEAD_BATT = 0;
  localparam int OPT_TRY_SRC   = 1;
  localparam int OPT_TRY_SNK   = 2;

  // Timeout and try limit constants.
  localparam logic [15:0] TOGGLE_TIMEOUT = 16'd40;
  localparam logic [2:0]  TRY_LIMIT      = 3'd5;

  // Configuration register file contents.
  typedef struct packed {
    logic [1:0]  role_mode;
    logic [15:0] cc_debounce_ticks;
    logic [15:0] pd_debounce_ticks;
    logic [15:0] try_cc_debounce_ticks;
    logic [15:0] drp_try_ticks;
    logic [15:0] drp_trywait_ticks;
    logic [15:0] error_recovery_ticks;
    logic [2:0]  option_flags;
  } cfg_t;

  // One input tick.
  typedef struct packed {
    logic [2:0] cc1_status;
    logic [2:0] cc2_status;
    logic       vbus_present;
    logic       vbus_safe5v;
    logic [1:0] toggle_result;
    logic       hold_for_swap;
    logic       force_recovery;
  } tick_t;

  // One result item.
  typedef struct packed {
    logic [3:0] conn_state;
    logic [1:0] cc_drive;
    logic       polarity;
    logic       gate_enable;
    logic       dummy_load;
    logic       power_role;
    logic [1:0] conn_event;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/typec_connection_state_machine_top.sv
// Top level of the USB Type-C connection state machine, one tick per beat.
// An accepted tick waits in the input register; its result is registered in the
// result register when that register has room.
// Throughput: one tick per cycle while the result channel is not stalled; the state
// update is one registered step between the input register and the result register.
// Reset: configuration returns to defaults, the state to sink unattached with
// its entry pending, and both stages empty. Depends on tcsm_pkg and submodules.
`default_nettype none

module typec_connection_state_machine_top
  import tcsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input tick channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cc1_status,
  input  wire logic [2:0]  cc2_status,
  input  wire logic        vbus_present,
  input  wire logic        vbus_safe5v,
  input  wire logic [1:0]  toggle_result,
  input  wire logic        hold_for_swap,
  input  wire logic        force_recovery,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       conn_state,
  output logic [1:0]       cc_drive,
  output logic             polarity,
  output logic             gate_enable,
  output logic             dummy_load,
  output logic             power_role,
  output logic [1:0]       conn_event
);

  cfg_t    cfg;
  tick_t   in_tick, held_tick;
  result_t step_result, out_result;
  logic    held_valid, load_ready, advance;

  // Pack the input fields into one beat.
  always_comb begin
    in_tick.cc1_status     = cc1_status;
    in_tick.cc2_status     = cc2_status;
    in_tick.vbus_present   = vbus_present;
    in_tick.vbus_safe5v    = vbus_safe5v;
    in_tick.toggle_result  = toggle_result;
    in_tick.hold_for_swap  = hold_for_swap;
    in_tick.force_recovery = force_recovery;
  end

  // A held tick moves to the result register when that register has room.
  assign advance = held_valid && load_ready;

  tcsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcsm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_tick    (in_tick),
    .take       (advance),
    .held_valid (held_valid),
    .held_tick  (held_tick)
  );

  tcsm_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .tick    (held_tick),
    .advance (advance),
    .result  (step_result)
  );

  tcsm_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (held_valid),
    .load_ready  (load_ready),
    .load_result (step_result),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  // Unpack the result beat onto the output fields.
  assign conn_state  = out_result.conn_state;
  assign cc_drive    = out_result.cc_drive;
  assign polarity    = out_result.polarity;
  assign gate_enable = out_result.gate_enable;
  assign dummy_load  = out_result.dummy_load;
  assign power_role  = out_result.power_role;
  assign conn_event  = out_result.conn_event;

endmodule

`default_nettype wire

// File: rtl/core/tcsm_cfg.sv
// Configuration register file for the connection state machine.
// Depends on tcsm_pkg for the register struct.
`default_nettype none

module tcsm_cfg
  import tcsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  localparam logic [2:0] REG_ROLE_MODE   = 3'd0;
  localparam logic [2:0] REG_CC_DEB      = 3'd1;
  localparam logic [2:0] REG_PD_DEB      = 3'd2;
  localparam logic [2:0] REG_TRY_CC_DEB  = 3'd3;
  localparam logic [2:0] REG_TRY_TICKS   = 3'd4;
  localparam logic [2:0] REG_TRYWAIT     = 3'd5;
  localparam logic [2:0] REG_ERR_REC     = 3'd6;
  localparam logic [2:0] REG_OPTIONS     = 3'd7;

  // Register writes; reset loads the documented defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.role_mode             <= ROLE_DRP;
      cfg.cc_debounce_ticks     <= 16'd20;
      cfg.pd_debounce_ticks     <= 16'd2;
      cfg.try_cc_debounce_ticks <= 16'd2;
      cfg.drp_try_ticks         <= 16'd15;
      cfg.drp_trywait_ticks     <= 16'd60;
      cfg.error_recovery_ticks  <= 16'd5;
      cfg.option_flags          <= 3'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROLE_MODE:  cfg.role_mode             <= cfg_data[1:0];
        REG_CC_DEB:     cfg.cc_debounce_ticks     <= cfg_data;
        REG_PD_DEB:     cfg.pd_debounce_ticks     <= cfg_data;
        REG_TRY_CC_DEB: cfg.try_cc_debounce_ticks <= cfg_data;
        REG_TRY_TICKS:  cfg.drp_try_ticks         <= cfg_data;
        REG_TRYWAIT:    cfg.drp_trywait_ticks     <= cfg_data;
        REG_ERR_REC:    cfg.error_recovery_ticks  <= cfg_data;
        REG_OPTIONS:    cfg.option_flags          <= cfg_data[2:0];
        default:        cfg.option_flags          <= cfg.option_flags;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcsm_in_reg.sv
// Input register stage: holds one accepted tick until the step logic takes it.
// Depends on tcsm_pkg for the tick struct.
`default_nettype none

module tcsm_in_reg
  import tcsm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire tick_t in_tick,
  input  wire logic  take,
  output logic       held_valid,
  output tick_t      held_tick
);

  // Space is free when empty or when the held beat leaves this cycle.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_tick <= in_tick;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcsm_step.sv
// Connection state registers and the single-tick next-state logic.
// Depends on tcsm_pkg for codes, configuration and item structs.
`default_nettype none

module tcsm_step
  import tcsm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire tick_t tick,
  input  wire logic  advance,
  output result_t    result
);

  typedef enum logic [3:0] {
    ST_DISABLED = 4'd0,
    ST_SNK_UN   = 4'd1,
    ST_SNK_AW   = 4'd2,
    ST_SNK_AT   = 4'd3,
    ST_SRC_UN   = 4'd4,
    ST_SRC_AW   = 4'd5,
    ST_SRC_AT   = 4'd6,
    ST_DEBUG    = 4'd7,
    ST_TOGGLE   = 4'd8,
    ST_TRY_SNK  = 4'd9,
    ST_TW_SRC   = 4'd10,
    ST_TRY_SRC  = 4'd11,
    ST_TW_SNK   = 4'd12,
    ST_ERR      = 4'd13
  } state_t;

  state_t      state, state_next;
  logic        entry_pending, entry_pending_next;
  logic [15:0] tick_timer, tick_timer_next, timer_inc;
  logic [2:0]  last_cc1, last_cc1_next, last_cc2, last_cc2_next;
  logic        active_polarity, active_polarity_next;
  logic [2:0]  try_src_count, try_src_count_next;
  logic [2:0]  try_snk_count, try_snk_count_next;
  logic [1:0]  cc_drive, cc_drive_next;
  logic        gate, gate_next, dummy, dummy_next, src_role, src_role_next;
  logic [1:0]  conn_event;

  logic [2:0]  c1, c2, act_cc;
  logic        dual, cc_changed, snk_conn, snk_disc, src_conn, src_disc, both_rd;

  // Line conditions seen by this tick.
  assign c1         = tick.cc1_status;
  assign c2         = tick.cc2_status;
  assign act_cc     = active_polarity ? c2 : c1;
  assign cc_changed = active_polarity ? (c2 != last_cc2) : (c1 != last_cc1);
  assign snk_conn   = (c1 != CCS_OPEN) || (c2 != CCS_OPEN);
  assign snk_disc   = (act_cc == CCS_OPEN);
  assign src_conn   = (c1 == CCS_RD) != (c2 == CCS_RD);
  assign src_disc   = (act_cc != CCS_RD);
  assign both_rd    = (c1 == CCS_RD) && (c2 == CCS_RD);
  assign dual       = cfg.role_mode[1];

  // Saturating tick timer increment.
  assign timer_inc = (tick_timer == 16'hFFFF) ? tick_timer : tick_timer + 16'd1;

  // Next-state logic for one tick: entry action or exit evaluation.
  always_comb begin
    state_next           = state;
    entry_pending_next   = entry_pending;
    tick_timer_next      = tick_timer;
    last_cc1_next        = last_cc1;
    last_cc2_next        = last_cc2;
    active_polarity_next = active_polarity;
    try_src_count_next   = try_src_count;
    try_snk_count_next   = try_snk_count;
    cc_drive_next        = cc_drive;
    gate_next            = gate;
    dummy_next           = dummy;
    src_role_next        = src_role;
    conn_event           = EVT_NONE;

    if (tick.hold_for_swap) begin
      state_next = state;
    end else if (tick.force_recovery) begin
      state_next         = ST_ERR;
      entry_pending_next = 1'b1;
    end else if (entry_pending) begin
      // Entry actions of the current state.
      entry_pending_next = 1'b0;
      unique case (state)
        ST_DISABLED: cc_drive_next = CC_OPEN;
        ST_SNK_UN: begin
          cc_drive_next      = CC_RD;
          gate_next          = 1'b0;
          tick_timer_next    = 16'd0;
          try_snk_count_next = 3'd0;
        end
        ST_SNK_AW, ST_SRC_AW: begin
          tick_timer_next = 16'd0;
          dummy_next      = 1'b1;
        end
        ST_SNK_AT: begin
          tick_timer_next = 16'd0;
          gate_next       = 1'b1;
          src_role_next   = 1'b0;
          conn_event      = EVT_ATTACHED;
        end
        ST_SRC_UN: begin
          cc_drive_next      = CC_RP;
          src_role_next      = 1'b1;
          gate_next          = 1'b0;
          tick_timer_next    = 16'd0;
          try_snk_count_next = 3'd0;
          try_src_count_next = 3'd0;
        end
        ST_SRC_AT: begin
          tick_timer_next = 16'd0;
          gate_next       = 1'b1;
          src_role_next   = 1'b1;
          conn_event      = EVT_ATTACHED;
        end
        ST_DEBUG: state_next = state;
        ST_TOGGLE: begin
          gate_next     = 1'b0;
          src_role_next = 1'b0;
          cc_drive_next = CC_TOG;
        end
        ST_TRY_SNK, ST_TW_SNK: begin
          cc_drive_next   = CC_RD;
          tick_timer_next = 16'd0;
        end
        ST_TW_SRC, ST_TRY_SRC: begin
          cc_drive_next   = CC_RP;
          tick_timer_next = 16'd0;
        end
        ST_ERR: begin
          cc_drive_next      = CC_OPEN;
          try_snk_count_next = 3'd0;
          try_src_count_next = 3'd0;
          src_role_next      = 1'b0;
          tick_timer_next    = 16'd0;
        end
        default: begin
          state_next         = ST_ERR;
          entry_pending_next = 1'b1;
        end
      endcase
    end else begin
      // Exit evaluation; most states also record the CC sample.
      last_cc1_next = c1;
      last_cc2_next = c2;
      unique case (state)
        ST_SNK_UN: begin
          if (snk_conn) begin
            active_polarity_next = (c1 == CCS_OPEN);
            state_next           = ST_SNK_AW;
            entry_pending_next   = 1'b1;
            conn_event           = EVT_TRY;
          end else if (dual) begin
            tick_timer_next = timer_inc;
            if (timer_inc >= TOGGLE_TIMEOUT) begin
              tick_timer_next    = 16'd0;
              state_next         = ST_TOGGLE;
              entry_pending_next = 1'b1;
            end
          end
        end
        ST_SNK_AW: begin
          tick_timer_next = timer_inc;
          if (cc_changed) begin
            state_next         = ST_SNK_AW;
            entry_pending_next = 1'b1;
          end else if (timer_inc > cfg.pd_debounce_ticks && snk_disc) begin
            state_next         = ST_SNK_UN;
            entry_pending_next = 1'b1;
          end else if (timer_inc > cfg.pd_debounce_ticks) begin
            dummy_next = 1'b0;
            if (tick.vbus_present) begin
              entry_pending_next = 1'b1;
              if (dual && cfg.option_flags[OPT_TRY_SRC] &&
                  try_src_count < TRY_LIMIT && !cfg.option_flags[OPT_DEAD_BATT]) begin
                try_src_count_next = try_src_count + 3'd1;
                state_next         = ST_TRY_SRC;
              end else begin
                state_next = ST_SNK_AT;
              end
            end
          end
        end
        ST_SNK_AT: begin
          if (snk_disc) begin
            tick_timer_next = timer_inc;
            if (timer_inc > cfg.pd_debounce_ticks) begin
              gate_next          = 1'b0;
              state_next         = ST_SNK_UN;
              entry_pending_next = 1'b1;
              conn_event         = EVT_DETACHED;
            end
          end else begin
            tick_timer_next = 16'd0;
          end
        end
        ST_SRC_UN: begin
          if (src_conn) begin
            active_polarity_next = (c1 != CCS_RD);
            conn_event           = EVT_TRY;
            state_next           = ST_SRC_AW;
            entry_pending_next   = 1'b1;
          end else if (dual) begin
            tick_timer_next = timer_inc;
            if (timer_inc >= TOGGLE_TIMEOUT) begin
              tick_timer_next    = 16'd0;
              state_next         = ST_TOGGLE;
              entry_pending_next = 1'b1;
            end
          end
        end
        ST_SRC_AW: begin
          tick_timer_next = timer_inc;
          if (cc_changed) begin
            state_next         = ST_SRC_AW;
            entry_pending_next = 1'b1;
          end else if (timer_inc > cfg.pd_debounce_ticks && src_disc) begin
            state_next         = ST_SRC_UN;
            entry_pending_next = 1'b1;
          end else if (timer_inc > cfg.cc_debounce_ticks) begin
            dummy_next = 1'b0;
            if (both_rd) begin
              state_next         = ST_DEBUG;
              entry_pending_next = 1'b1;
            end else if (src_conn) begin
              if (dual && cfg.option_flags[OPT_TRY_SNK]) begin
                entry_pending_next = 1'b1;
                if (try_snk_count >= TRY_LIMIT) begin
                  state_next = ST_SRC_AT;
                end else begin
                  try_snk_count_next = try_snk_count + 3'd1;
                  state_next         = ST_TRY_SNK;
                end
              end else if (tick.vbus_safe5v) begin
                state_next         = ST_SRC_AT;
                entry_pending_next = 1'b1;
              end
            end
          end
        end
        ST_SRC_AT: begin
          if (src_disc) begin
            tick_timer_next = timer_inc;
            if (timer_inc > cfg.pd_debounce_ticks) begin
              state_next         = ST_SRC_UN;
              entry_pending_next = 1'b1;
              conn_event         = EVT_DETACHED;
            end
          end else begin
            tick_timer_next = 16'd0;
          end
        end
        ST_DEBUG: begin
          if (!both_rd) begin
            tick_timer_next = timer_inc;
            if (timer_inc > cfg.pd_debounce_ticks) begin
              state_next         = ST_SRC_UN;
              entry_pending_next = 1'b1;
            end
          end else begin
            tick_timer_next = 16'd0;
          end
        end
        ST_TOGGLE: begin
          last_cc1_next = last_cc1;
          last_cc2_next = last_cc2;
          if (tick.toggle_result == TOG_SNK) begin
            state_next         = ST_SNK_UN;
            entry_pending_next = 1'b1;
          end else if (tick.toggle_result == TOG_SRC) begin
            state_next         = ST_SRC_UN;
            entry_pending_next = 1'b1;
          end
        end
        ST_TRY_SNK: begin
          tick_timer_next = timer_inc;
          if (cc_changed) begin
            state_next         = ST_TRY_SNK;
            entry_pending_next = 1'b1;
          end else begin
            // The timeout check wins when both hold.
            if (snk_conn && timer_inc > cfg.try_cc_debounce_ticks) begin
              state_next         = ST_SNK_AT;
              entry_pending_next = 1'b1;
            end
            if (snk_disc && timer_inc > cfg.drp_trywait_ticks) begin
              state_next         = ST_TW_SRC;
              entry_pending_next = 1'b1;
            end
          end
        end
        ST_TW_SRC: begin
          tick_timer_next = timer_inc;
          if (cc_changed) begin
            state_next         = ST_TW_SRC;
            entry_pending_next = 1'b1;
          end else if (src_disc && timer_inc > cfg.pd_debounce_ticks) begin
            state_next         = ST_SRC_UN;
            entry_pending_next = 1'b1;
          end else if (src_conn && timer_inc > cfg.cc_debounce_ticks) begin
            state_next         = ST_SRC_AT;
            entry_pending_next = 1'b1;
          end
        end
        ST_TRY_SRC: begin
          tick_timer_next = timer_inc;
          if (cc_changed) begin
            state_next         = ST_TRY_SRC;
            entry_pending_next = 1'b1;
          end else begin
            if (src_conn && timer_inc > cfg.try_cc_debounce_ticks) begin
              state_next         = ST_SRC_AT;
              entry_pending_next = 1'b1;
            end
            if (src_disc && timer_inc > cfg.drp_try_ticks) begin
              state_next         = ST_TW_SNK;
              entry_pending_next = 1'b1;
            end
          end
        end
        ST_TW_SNK: begin
          tick_timer_next = timer_inc;
          if (cc_changed) begin
            state_next         = ST_TW_SNK;
            entry_pending_next = 1'b1;
          end else if (snk_disc && timer_inc > cfg.pd_debounce_ticks) begin
            state_next         = ST_SRC_UN;
            entry_pending_next = 1'b1;
          end else if (snk_conn && timer_inc > cfg.pd_debounce_ticks &&
                       tick.vbus_present) begin
            state_next         = ST_SNK_AT;
            entry_pending_next = 1'b1;
          end
        end
        ST_ERR: begin
          last_cc1_next   = last_cc1;
          last_cc2_next   = last_cc2;
          tick_timer_next = timer_inc;
          if (timer_inc > cfg.error_recovery_ticks) begin
            state_next         = (cfg.role_mode == ROLE_SRC) ? ST_SRC_UN : ST_SNK_UN;
            entry_pending_next = 1'b1;
          end
        end
        ST_DISABLED: begin
          last_cc1_next = last_cc1;
          last_cc2_next = last_cc2;
        end
        default: begin
          last_cc1_next      = last_cc1;
          last_cc2_next      = last_cc2;
          state_next         = ST_ERR;
          entry_pending_next = 1'b1;
        end
      endcase
    end
  end

  // State registers advance once per tick taken from the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_SNK_UN;
      entry_pending   <= 1'b1;
      tick_timer      <= 16'd0;
      last_cc1        <= 3'd0;
      last_cc2        <= 3'd0;
      active_polarity <= 1'b0;
      try_src_count   <= 3'd0;
      try_snk_count   <= 3'd0;
      cc_drive        <= CC_OPEN;
      gate            <= 1'b0;
      dummy           <= 1'b0;
      src_role        <= 1'b0;
    end else if (advance) begin
      state           <= state_next;
      entry_pending   <= entry_pending_next;
      tick_timer      <= tick_timer_next;
      last_cc1        <= last_cc1_next;
      last_cc2        <= last_cc2_next;
      active_polarity <= active_polarity_next;
      try_src_count   <= try_src_count_next;
      try_snk_count   <= try_snk_count_next;
      cc_drive        <= cc_drive_next;
      gate            <= gate_next;
      dummy           <= dummy_next;
      src_role        <= src_role_next;
    end
  end

  // Result reflects the state after this tick.
  always_comb begin
    result.conn_state  = state_next;
    result.cc_drive    = cc_drive_next;
    result.polarity    = active_polarity_next;
    result.gate_enable = gate_next;
    result.dummy_load  = dummy_next;
    result.power_role  = src_role_next;
    result.conn_event  = conn_event;
  end

endmodule

`default_nettype wire

// File: rtl/core/tcsm_out_reg.sv
// Result register: holds one result beat until the consumer takes it.
// Depends on tcsm_pkg for the result struct.
`default_nettype none

module tcsm_out_reg
  import tcsm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  output logic         load_ready,
  input  wire result_t load_result,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  // Room for a new beat when empty or when the current one is taken now.
  assign load_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      out_result <= load_result;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for typec_connection_state_machine_top: sends CC/VBUS ticks with random
// idling and checks every result beat against a port model kept in this file.
// Depends on tcsm_pkg for the payload structs and the CC, event and role codes.
module testbench;
  import tcsm_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int IDLE_LIMIT = 1000;

  // Connection state codes as they appear on conn_state.
  typedef enum logic [3:0] {
    PS_DISABLED, PS_SNK_UNATT, PS_SNK_WAIT, PS_SNK_ATT, PS_SRC_UNATT, PS_SRC_WAIT,
    PS_SRC_ATT, PS_DEBUG_ATT, PS_DRP_TOGGLE, PS_TRY_SNK, PS_TRYWAIT_SRC, PS_TRY_SRC,
    PS_TRYWAIT_SNK, PS_ERR_RECOVERY
  } port_state_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ROLE_MODE, REG_CC_DEBOUNCE, REG_PD_DEBOUNCE, REG_TRY_CC_DEBOUNCE,
    REG_DRP_TRY, REG_DRP_TRYWAIT, REG_ERR_RECOVERY, REG_OPTIONS
  } cfg_reg_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tick_t       tick_drv = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  conn_state;
  logic [1:0]  cc_drive;
  logic        polarity;
  logic        gate_enable;
  logic        dummy_load;
  logic        power_role;
  logic [1:0]  conn_event;

  // Shared run control.
  logic        idle_enable = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;
  result_t     pending_status[$];

  // Port model: configuration copy.
  logic [1:0]  role_mode;
  logic [15:0] cc_debounce, pd_debounce, try_debounce;
  logic [15:0] try_src_timeout, try_snk_timeout, recovery_ticks;
  logic [2:0]  options;

  // Port model: state.
  port_state_e st;
  logic        entry_due;
  logic [15:0] tick_count;
  logic [2:0]  prev_cc1, prev_cc2;
  logic        pol;
  logic [2:0]  try_src_tries, try_snk_tries;
  logic [1:0]  cc_drv;
  logic        gate_on, dummy_on, source_role;
  logic [1:0]  event_code;
  tick_t       now_tick;

  typec_connection_state_machine_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cc1_status(tick_drv.cc1_status),
    .cc2_status(tick_drv.cc2_status),
    .vbus_present(tick_drv.vbus_present),
    .vbus_safe5v(tick_drv.vbus_safe5v),
    .toggle_result(tick_drv.toggle_result),
    .hold_for_swap(tick_drv.hold_for_swap),
    .force_recovery(tick_drv.force_recovery),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .conn_state(conn_state),
    .cc_drive(cc_drive),
    .polarity(polarity),
    .gate_enable(gate_enable),
    .dummy_load(dummy_load),
    .power_role(power_role),
    .conn_event(conn_event)
  );

  // Clock with a 12 unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model helpers.
  function automatic void move_to(port_state_e s);
    st = s;
    entry_due = 1'b1;
  endfunction

  function automatic void bump_timer();
    if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
  endfunction

  function automatic logic [2:0] active_cc();
    return pol ? now_tick.cc2_status : now_tick.cc1_status;
  endfunction

  function automatic logic cc_moved();
    return pol ? (now_tick.cc2_status != prev_cc2) : (now_tick.cc1_status != prev_cc1);
  endfunction

  function automatic logic sink_seen();
    return now_tick.cc1_status != CCS_OPEN || now_tick.cc2_status != CCS_OPEN;
  endfunction

  function automatic logic sink_gone();
    return active_cc() == CCS_OPEN;
  endfunction

  function automatic logic source_seen();
    return (now_tick.cc1_status == CCS_RD) != (now_tick.cc2_status == CCS_RD);
  endfunction

  function automatic logic source_gone();
    return active_cc() != CCS_RD;
  endfunction

  function automatic logic dual_role();
    return role_mode >= ROLE_DRP;
  endfunction

  // While unattached in dual role, a long quiet spell hands over to the toggler.
  function automatic void count_toward_toggle();
    if (dual_role()) begin
      bump_timer();
      if (tick_count >= TOGGLE_TIMEOUT) begin
        tick_count = '0;
        move_to(PS_DRP_TOGGLE);
      end
    end
  endfunction

  // One tick of the port: swap hold, forced recovery, else an entry or an exit step.
  function automatic result_t advance_port(tick_t t);
    result_t r;
    logic keep_cc;
    now_tick = t;
    event_code = EVT_NONE;
    if (!t.hold_for_swap) begin
      if (t.force_recovery) begin
        move_to(PS_ERR_RECOVERY);
      end else if (entry_due) begin
        entry_due = 1'b0;
        case (st)
          PS_DISABLED: cc_drv = CC_OPEN;
          PS_SNK_UNATT: begin
            cc_drv = CC_RD;
            gate_on = 1'b0;
            tick_count = '0;
            try_snk_tries = '0;
          end
          PS_SNK_WAIT, PS_SRC_WAIT: begin
            tick_count = '0;
            dummy_on = 1'b1;
          end
          PS_SNK_ATT: begin
            tick_count = '0;
            gate_on = 1'b1;
            source_role = 1'b0;
            event_code = EVT_ATTACHED;
          end
          PS_SRC_UNATT: begin
            cc_drv = CC_RP;
            source_role = 1'b1;
            gate_on = 1'b0;
            tick_count = '0;
            try_snk_tries = '0;
            try_src_tries = '0;
          end
          PS_SRC_ATT: begin
            tick_count = '0;
            gate_on = 1'b1;
            source_role = 1'b1;
            event_code = EVT_ATTACHED;
          end
          // A debug accessory keeps its state and its timer on entry.
          PS_DEBUG_ATT: ;
          PS_DRP_TOGGLE: begin
            gate_on = 1'b0;
            source_role = 1'b0;
            cc_drv = CC_TOG;
          end
          PS_TRY_SNK, PS_TRYWAIT_SNK: begin
            cc_drv = CC_RD;
            tick_count = '0;
          end
          PS_TRYWAIT_SRC, PS_TRY_SRC: begin
            cc_drv = CC_RP;
            tick_count = '0;
          end
          PS_ERR_RECOVERY: begin
            cc_drv = CC_OPEN;
            try_snk_tries = '0;
            try_src_tries = '0;
            source_role = 1'b0;
            tick_count = '0;
          end
          default: move_to(PS_ERR_RECOVERY);
        endcase
      end else begin
        // The toggler, recovery and disabled states do not track CC history.
        keep_cc = (st != PS_DRP_TOGGLE) && (st != PS_ERR_RECOVERY) && (st != PS_DISABLED);
        case (st)
          PS_SNK_UNATT: begin
            if (sink_seen()) begin
              pol = (t.cc1_status != CCS_OPEN) ? 1'b0 : 1'b1;
              move_to(PS_SNK_WAIT);
              event_code = EVT_TRY;
            end else begin
              count_toward_toggle();
            end
          end
          PS_SNK_WAIT: begin
            bump_timer();
            if (cc_moved()) begin
              move_to(PS_SNK_WAIT);
            end else if (tick_count > pd_debounce && sink_gone()) begin
              move_to(PS_SNK_UNATT);
            end else if (tick_count > pd_debounce) begin
              dummy_on = 1'b0;
              if (t.vbus_present) begin
                if (dual_role() && options[OPT_TRY_SRC]) begin
                  if (try_src_tries >= TRY_LIMIT || options[OPT_DEAD_BATT]) begin
                    move_to(PS_SNK_ATT);
                  end else begin
                    try_src_tries = try_src_tries + 3'd1;
                    move_to(PS_TRY_SRC);
                  end
                end else begin
                  move_to(PS_SNK_ATT);
                end
              end
            end
          end
          PS_SNK_ATT: begin
            if (sink_gone()) begin
              bump_timer();
              if (tick_count > pd_debounce) begin
                gate_on = 1'b0;
                move_to(PS_SNK_UNATT);
                event_code = EVT_DETACHED;
              end
            end else begin
              tick_count = '0;
            end
          end
          PS_SRC_UNATT: begin
            if (source_seen()) begin
              pol = (t.cc1_status == CCS_RD) ? 1'b0 : 1'b1;
              event_code = EVT_TRY;
              move_to(PS_SRC_WAIT);
            end else begin
              count_toward_toggle();
            end
          end
          PS_SRC_WAIT: begin
            bump_timer();
            if (cc_moved()) begin
              move_to(PS_SRC_WAIT);
            end else if (tick_count > pd_debounce && source_gone()) begin
              move_to(PS_SRC_UNATT);
            end else if (tick_count > cc_debounce) begin
              dummy_on = 1'b0;
              if (t.cc1_status == CCS_RD && t.cc2_status == CCS_RD) begin
                move_to(PS_DEBUG_ATT);
              end else if (source_seen()) begin
                if (dual_role() && options[OPT_TRY_SNK]) begin
                  if (try_snk_tries >= TRY_LIMIT) begin
                    move_to(PS_SRC_ATT);
                  end else begin
                    try_snk_tries = try_snk_tries + 3'd1;
                    move_to(PS_TRY_SNK);
                  end
                end else if (t.vbus_safe5v) begin
                  move_to(PS_SRC_ATT);
                end
              end
            end
          end
          PS_SRC_ATT: begin
            if (source_gone()) begin
              bump_timer();
              if (tick_count > pd_debounce) begin
                move_to(PS_SRC_UNATT);
                event_code = EVT_DETACHED;
              end
            end else begin
              tick_count = '0;
            end
          end
          PS_DEBUG_ATT: begin
            if (t.cc1_status != CCS_RD || t.cc2_status != CCS_RD) begin
              bump_timer();
              if (tick_count > pd_debounce) move_to(PS_SRC_UNATT);
            end else begin
              tick_count = '0;
            end
          end
          // Any other toggle code counts as no result.
          PS_DRP_TOGGLE: begin
            if (t.toggle_result == TOG_SNK) move_to(PS_SNK_UNATT);
            else if (t.toggle_result == TOG_SRC) move_to(PS_SRC_UNATT);
          end
          PS_TRY_SNK: begin
            bump_timer();
            if (cc_moved()) begin
              move_to(PS_TRY_SNK);
            end else begin
              if (sink_seen() && tick_count > try_debounce) move_to(PS_SNK_ATT);
              if (sink_gone() && tick_count > try_snk_timeout) move_to(PS_TRYWAIT_SRC);
            end
          end
          PS_TRYWAIT_SRC: begin
            bump_timer();
            if (cc_moved()) move_to(PS_TRYWAIT_SRC);
            else if (source_gone() && tick_count > pd_debounce) move_to(PS_SRC_UNATT);
            else if (source_seen() && tick_count > cc_debounce) move_to(PS_SRC_ATT);
          end
          PS_TRY_SRC: begin
            bump_timer();
            if (cc_moved()) begin
              move_to(PS_TRY_SRC);
            end else begin
              if (source_seen() && tick_count > try_debounce) move_to(PS_SRC_ATT);
              if (source_gone() && tick_count > try_src_timeout) move_to(PS_TRYWAIT_SNK);
            end
          end
          PS_TRYWAIT_SNK: begin
            bump_timer();
            if (cc_moved()) begin
              move_to(PS_TRYWAIT_SNK);
            end else if (sink_gone() && tick_count > pd_debounce) begin
              move_to(PS_SRC_UNATT);
            end else if (sink_seen() && tick_count > pd_debounce && t.vbus_present) begin
              move_to(PS_SNK_ATT);
            end
          end
          PS_ERR_RECOVERY: begin
            bump_timer();
            if (tick_count > recovery_ticks) begin
              move_to(role_mode == ROLE_SRC ? PS_SRC_UNATT : PS_SNK_UNATT);
            end
          end
          PS_DISABLED: ;
          default: move_to(PS_ERR_RECOVERY);
        endcase
        if (keep_cc) begin
          prev_cc1 = t.cc1_status;
          prev_cc2 = t.cc2_status;
        end
      end
    end
    r.conn_state  = st;
    r.cc_drive    = cc_drv;
    r.polarity    = pol;
    r.gate_enable = gate_on;
    r.dummy_load  = dummy_on;
    r.power_role  = source_role;
    r.conn_event  = event_code;
    return r;
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Result side backpressure, changed at the falling edge.
  always @(negedge clk) begin
    if (stall_left == 0) stall_left = pick_idle();
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Every accepted tick beat is run through the model right away.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) pending_status.push_back(advance_port(tick_drv));
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest predicted status.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("result beat with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("conn_state", want.conn_state, conn_state);
        check_field("cc_drive", want.cc_drive, cc_drive);
        check_field("polarity", want.polarity, polarity);
        check_field("gate_enable", want.gate_enable, gate_enable);
        check_field("dummy_load", want.dummy_load, dummy_load);
        check_field("power_role", want.power_role, power_role);
        check_field("conn_event", want.conn_event, conn_event);
      end
    end
  end

  // Hang detection: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one tick beat, optionally after an idle gap.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = pick_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_drv = t;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input logic [2:0] c1, input logic [2:0] c2, input logic vp,
                             input logic vs, input logic [1:0] tog, input logic hold,
                             input logic force_err);
    tick_t t;
    t.cc1_status = c1;
    t.cc2_status = c2;
    t.vbus_present = vp;
    t.vbus_safe5v = vs;
    t.toggle_result = tog;
    t.hold_for_swap = hold;
    t.force_recovery = force_err;
    send_tick(t);
  endtask

  // Drain all outstanding results, then write every register in index order.
  task automatic apply_config(input logic [15:0] role, input logic [15:0] ccd,
                              input logic [15:0] pdd, input logic [15:0] tryd,
                              input logic [15:0] try_to, input logic [15:0] trywait_to,
                              input logic [15:0] err_to, input logic [15:0] opts);
    logic [15:0] v [0:7];
    v[0] = role; v[1] = ccd; v[2] = pdd; v[3] = tryd;
    v[4] = try_to; v[5] = trywait_to; v[6] = err_to; v[7] = opts;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_write = 1'b1;
      cfg_index = cfg_reg_e'(i);
      cfg_data = v[i];
      case (cfg_reg_e'(i))
        REG_ROLE_MODE:       role_mode = v[i][1:0];
        REG_CC_DEBOUNCE:     cc_debounce = v[i];
        REG_PD_DEBOUNCE:     pd_debounce = v[i];
        REG_TRY_CC_DEBOUNCE: try_debounce = v[i];
        REG_DRP_TRY:         try_src_timeout = v[i];
        REG_DRP_TRYWAIT:     try_snk_timeout = v[i];
        REG_ERR_RECOVERY:    recovery_ticks = v[i];
        REG_OPTIONS:         options = v[i][2:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_write = 1'b0;
  endtask

  // Runs of steady CC terminations with random length, so debounces can settle,
  // with VBUS, toggle results, swap holds and forced recovery sprinkled in.
  task automatic drive_runs(input int count);
    logic [2:0] c1, c2;
    logic vbus;
    int run_len, r;
    tick_t t;
    while (count > 0) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      c1 = $urandom_range(0, 7);
      c2 = $urandom_range(0, 7);
      if (r < 25) begin
        c1 = CCS_OPEN;
        c2 = CCS_OPEN;
      end else if (r < 45) begin
        // Exactly one Rd, as a sink shows itself to a source.
        c1 = CCS_RD;
        if (c2 == CCS_RD) c2 = CCS_OPEN;
        if ($urandom_range(0, 1) != 0) {c1, c2} = {c2, c1};
      end else if (r < 55) begin
        c1 = CCS_RD;
        c2 = CCS_RD;
      end else if (r < 75) begin
        // One termination on one pin, as a source shows itself to a sink.
        c1 = $urandom_range(1, 7);
        c2 = CCS_OPEN;
        if ($urandom_range(0, 1) != 0) {c1, c2} = {c2, c1};
      end
      vbus = ($urandom_range(0, 4) != 0);
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 8);
      repeat (run_len < count ? run_len : count) begin
        t.cc1_status = c1;
        t.cc2_status = c2;
        t.vbus_present = ($urandom_range(0, 19) == 0) ? !vbus : vbus;
        t.vbus_safe5v = ($urandom_range(0, 9) == 0) ? !t.vbus_present : t.vbus_present;
        t.toggle_result = $urandom_range(0, 3);
        t.hold_for_swap = ($urandom_range(0, 39) == 0);
        t.force_recovery = ($urandom_range(0, 59) == 0);
        send_tick(t);
      end
      count -= run_len;
    end
  endtask

  // Reset defaults: field extremes, swap hold over forced recovery, a sink
  // attach on CC1, recovery timeout, a sink attach wait on CC2 and a CC change.
  task automatic test_field_extremes();
    send_fields(3'd0, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0);
    send_fields(3'd7, 3'd7, 1'b1, 1'b1, 2'd3, 1'b1, 1'b0);
    send_fields(3'd7, 3'd0, 1'b1, 1'b1, 2'd3, 1'b0, 1'b0);
    send_fields(3'd7, 3'd0, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0);
    repeat (3) send_fields(3'd7, 3'd0, 1'b1, 1'b0, TOG_SNK, 1'b0, 1'b0);
    send_fields(3'd7, 3'd0, 1'b1, 1'b0, TOG_SRC, 1'b0, 1'b0);
    send_fields(3'd0, 3'd7, 1'b0, 1'b0, 2'd0, 1'b1, 1'b1);
    send_fields(3'd0, 3'd7, 1'b0, 1'b0, 2'd0, 1'b0, 1'b1);
    send_fields(3'd0, 3'd0, 1'b0, 1'b0, 2'd3, 1'b0, 1'b0);
    repeat (7) send_fields(3'd0, 3'd0, 1'b0, 1'b1, TOG_SRC, 1'b0, 1'b0);
    send_fields(3'd0, 3'd7, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0);
    send_fields(3'd0, 3'd7, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0);
    send_fields(3'd0, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0);
    send_fields(3'd1, 3'd1, 1'b1, 1'b1, TOG_SRC, 1'b0, 1'b0);
  endtask

  task automatic test_sink_only();
    apply_config(16'd0, $urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 4),
                 $urandom_range(0, 10), $urandom_range(0, 12), $urandom_range(0, 4),
                 $urandom_range(0, 7));
    drive_runs(60);
  endtask

  task automatic test_source_only();
    apply_config(ROLE_SRC, $urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 4),
                 $urandom_range(0, 10), $urandom_range(0, 12), $urandom_range(0, 4),
                 $urandom_range(0, 7));
    drive_runs(60);
  endtask

  // Dual role with random options, then the spare role code that acts as dual role.
  task automatic test_dual_role();
    apply_config(ROLE_DRP, $urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(0, 8), $urandom_range(0, 10), $urandom_range(0, 3),
                 $urandom_range(0, 7));
    drive_runs(60);
    apply_config(ROLE_DRP | ROLE_SRC, $urandom_range(0, 6), $urandom_range(0, 3),
                 $urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 10),
                 $urandom_range(0, 3), $urandom_range(0, 7));
    drive_runs(60);
  endtask

  // Try.SRC and Try.SNK enabled, then again with the dead battery option.
  task automatic test_try_roles();
    apply_config(ROLE_DRP, $urandom_range(0, 4), $urandom_range(0, 2), $urandom_range(0, 3),
                 $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 2),
                 (1 << OPT_TRY_SRC) | (1 << OPT_TRY_SNK));
    drive_runs(60);
    apply_config(ROLE_DRP, $urandom_range(0, 4), $urandom_range(0, 2), $urandom_range(0, 3),
                 $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 2),
                 (1 << OPT_DEAD_BATT) | (1 << OPT_TRY_SRC) | (1 << OPT_TRY_SNK));
    drive_runs(50);
  endtask

  // All timings at zero, then all at the saturating maximum.
  task automatic test_timing_extremes();
    apply_config(ROLE_DRP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                 (1 << OPT_TRY_SRC) | (1 << OPT_TRY_SNK));
    drive_runs(40);
    apply_config(ROLE_SRC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF);
    drive_runs(25);
  endtask

  initial begin
    // Model state after reset matches the block's defaults.
    role_mode = ROLE_DRP;
    cc_debounce = 16'd20;
    pd_debounce = 16'd2;
    try_debounce = 16'd2;
    try_src_timeout = 16'd15;
    try_snk_timeout = 16'd60;
    recovery_ticks = 16'd5;
    options = '0;
    st = (role_mode == ROLE_SRC) ? PS_SRC_UNATT : PS_SNK_UNATT;
    entry_due = 1'b1;
    tick_count = '0;
    prev_cc1 = '0;
    prev_cc2 = '0;
    pol = 1'b0;
    try_src_tries = '0;
    try_snk_tries = '0;
    cc_drv = CC_OPEN;
    gate_on = 1'b0;
    dummy_on = 1'b0;
    source_role = 1'b0;
    event_code = EVT_NONE;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_sink_only();
    test_source_only();
    test_dual_role();
    test_try_roles();
    test_timing_extremes();

    // Drain the pipeline, then wait for any stray beats before the verdict.
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
